// File: rtl/id3p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_pkg
// Shared types and constants of the ID3v2 tag frame parser.
// ----------------------------------------------------------------------------
package id3p_pkg;

  // Result event codes
  typedef enum logic [1:0] {
    EV_TAG_HDR     = 2'd0,
    EV_NOT_ID3     = 2'd1,
    EV_FRAME_START = 2'd2,
    EV_TEXT_BYTE   = 2'd3
  } event_t;

  // Text frame kinds
  typedef enum logic [2:0] {
    KIND_TITLE  = 3'd0,
    KIND_ARTIST = 3'd1,
    KIND_ALBUM  = 3'd2,
    KIND_YEAR   = 3'd3,
    KIND_GENRE  = 3'd4
  } kind_t;

  // Signature "ID3"
  localparam logic [7:0] SIG_B0 = 8'h49;
  localparam logic [7:0] SIG_B1 = 8'h44;
  localparam logic [7:0] SIG_B2 = 8'h33;

  // Known text frame IDs, indexed by kind
  localparam int NUM_TEXT_IDS = 5;
  localparam logic [31:0] TEXT_IDS [NUM_TEXT_IDS] = '{
    32'h5449_5432,  // TIT2
    32'h5450_4531,  // TPE1
    32'h5441_4C42,  // TALB
    32'h5444_5243,  // TDRC
    32'h5443_4F4E   // TCON
  };

  // Syncsafe byte positions (unmasked OR of shifted bytes)
  localparam int SS_SHIFT0 = 21;
  localparam int SS_SHIFT1 = 14;
  localparam int SS_SHIFT2 = 7;

  // Frame header length in bytes
  localparam int FHDR_LEN = 10;

  // Input item
  typedef struct packed {
    logic       start_req;
    logic [7:0] data_byte;
  } item_t;

  // Result item
  typedef struct packed {
    event_t      event_res;
    logic [2:0]  frame_kind;
    logic [7:0]  text_byte;
    logic        last_of_frame;
    logic [7:0]  major_version;
    logic [7:0]  minor_version;
    logic [7:0]  tag_flags;
    logic [28:0] tag_size;
  } result_t;

  // Handshake between the input register and the parser
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage : id3p_pkg
`default_nettype wire

// File: rtl/id3p_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_in_if
// Byte stream channel: valid/ready with start marker and data byte.
// ----------------------------------------------------------------------------
interface id3p_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] data_byte;

  modport source (output valid, output start_req, output data_byte, input ready);
  modport sink   (input valid, input start_req, input data_byte, output ready);
endinterface : id3p_in_if
`default_nettype wire

// File: rtl/id3p_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_out_if
// Result channel: valid/ready with tag header and text frame fields.
// ----------------------------------------------------------------------------
interface id3p_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [2:0]  frame_kind;
  logic [7:0]  text_byte;
  logic        last_of_frame;
  logic [7:0]  major_version;
  logic [7:0]  minor_version;
  logic [7:0]  tag_flags;
  logic [28:0] tag_size;

  modport source (
    output valid, output event_res, output frame_kind, output text_byte,
    output last_of_frame, output major_version, output minor_version,
    output tag_flags, output tag_size, input ready
  );
  modport sink (
    input valid, input event_res, input frame_kind, input text_byte,
    input last_of_frame, input major_version, input minor_version,
    input tag_flags, input tag_size, output ready
  );
endinterface : id3p_out_if
`default_nettype wire

// File: rtl/id3v2_tag_frame_parser_top.sv
`default_nettype none
// A byte waits in the input register, is parsed, and its result item is registered in the result register.
// Throughput: one byte per cycle while the result register can take a result; the parser state updates once per byte.
// The input and result registers let a new byte enter while a result waits.
// Reset: synchronous, active low; the parser returns to idle, no clearing pass.
// ----------------------------------------------------------------------------
// id3v2_tag_frame_parser_top
// ID3v2 tag and text frame parser over a byte stream.
// ----------------------------------------------------------------------------
module id3v2_tag_frame_parser_top
  import id3p_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  id3p_in_if.sink    in_if,
  id3p_out_if.source out_if
);

  stage_t  stage;
  logic    out_free;
  logic    fire;
  logic    res_valid;
  result_t res;

  // an item is parsed when held and the result slot can take it
  assign fire = stage.valid && out_free;

  id3p_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .take  (out_free),
    .stage (stage)
  );

  id3p_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (stage.item),
    .res_valid (res_valid),
    .res       (res)
  );

  id3p_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_if    (out_if)
  );

endmodule : id3v2_tag_frame_parser_top
`default_nettype wire

// File: rtl/id3p_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_in_reg
// Input register: holds one accepted item until the parser takes it.
// ----------------------------------------------------------------------------
module id3p_in_reg
  import id3p_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  id3p_in_if.sink    in_if,
  input  wire logic  take,     // parser consumes the held item this cycle
  output stage_t     stage
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  // free when empty or being drained
  assign in_if.ready = !valid_r || take;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.start_req <= in_if.start_req;
      item_r.data_byte <= in_if.data_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule : id3p_in_reg
`default_nettype wire

// File: rtl/id3p_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_core
// Parser state and next-state logic: tag header, frame headers, text bytes.
// ----------------------------------------------------------------------------
module id3p_core
  import id3p_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,        // item processed this cycle
  input  wire item_t item,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_HDR  = 8'b0000_0010,
    PH_BAD  = 8'b0000_0100,
    PH_FHDR = 8'b0000_1000,
    PH_SKIP = 8'b0001_0000,
    PH_ENC  = 8'b0010_0000,
    PH_TEXT = 8'b0100_0000,
    PH_DONE = 8'b1000_0000
  } phase_t;

  // next frame header fits inside the tag
  function automatic logic frame_fits(input logic [30:0] cons, input logic [28:0] size);
    logic [31:0] need;
    need = {1'b0, cons} + 32'(FHDR_LEN);
    return need <= {3'b0, size};
  endfunction

  // OR one syncsafe byte into its position
  function automatic logic [28:0] ss_or(input logic [28:0] acc, input logic [7:0] b,
                                        input logic [1:0] pos);
    logic [28:0] ext;
    ext = {21'b0, b};
    unique case (pos)
      2'd0:    return acc | (ext << SS_SHIFT0);
      2'd1:    return acc | (ext << SS_SHIFT1);
      2'd2:    return acc | (ext << SS_SHIFT2);
      default: return acc | ext;
    endcase
  endfunction

  // signature byte for a position
  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    unique case (pos)
      2'd0:    return SIG_B0;
      2'd1:    return SIG_B1;
      default: return SIG_B2;
    endcase
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [28:0] size_r, size_nxt;
  logic [30:0] cons_r, cons_nxt;
  logic [31:0] id_r, id_nxt;
  logic [28:0] len_r, len_nxt;
  logic [28:0] left_r, left_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  vhi_r, vhi_nxt;
  logic [7:0]  vlo_r, vlo_nxt;
  logic [7:0]  flg_r, flg_nxt;

  // state as seen by this item (start restarts at the signature)
  phase_t      ph_c;
  logic [3:0]  idx_c;
  logic [28:0] size_c;
  logic [30:0] cons_c;

  logic [7:0]  b;
  logic [28:0] size_new;
  logic [31:0] id_new;
  logic [31:0] total;
  logic [30:0] cons_new;
  logic [28:0] left_dec;
  logic        known;
  logic [2:0]  kind_hit;

  assign b        = item.data_byte;
  assign ph_c     = item.start_req ? PH_HDR : phase_r;
  assign idx_c    = item.start_req ? 4'd0 : idx_r;
  assign size_c   = item.start_req ? 29'd0 : size_r;
  assign cons_c   = item.start_req ? 31'd0 : cons_r;

  assign size_new = ss_or(size_c, b, 2'(idx_c - 4'd6));
  assign id_new   = {id_r[23:0], b};
  assign total    = {1'b0, cons_c} + 32'(FHDR_LEN) + {3'b0, len_r};
  assign cons_new = total[30:0];
  assign left_dec = left_r - 29'd1;

  // frame ID match against the known text frames
  always_comb begin
    known    = 1'b0;
    kind_hit = 3'd0;
    for (int k = 0; k < NUM_TEXT_IDS; k++) begin
      if (id_r == TEXT_IDS[k]) begin
        known    = 1'b1;
        kind_hit = 3'(k);
      end
    end
  end

  // next state and result
  always_comb begin
    phase_nxt = ph_c;
    idx_nxt   = idx_c;
    size_nxt  = size_c;
    cons_nxt  = cons_c;
    id_nxt    = id_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    kind_nxt  = kind_r;
    vhi_nxt   = vhi_r;
    vlo_nxt   = vlo_r;
    flg_nxt   = flg_r;
    res_valid = 1'b0;
    res       = '0;

    unique case (ph_c)
      PH_HDR: begin
        idx_nxt = idx_c + 4'd1;
        priority if (idx_c < 4'd3) begin
          if (b != sig_byte(idx_c[1:0])) begin
            if (idx_c == 4'd2) begin
              phase_nxt     = PH_DONE;
              idx_nxt       = idx_c;
              res_valid     = 1'b1;
              res.event_res = EV_NOT_ID3;
            end else begin
              phase_nxt = PH_BAD;
            end
          end
        end else if (idx_c == 4'd3) begin
          vhi_nxt = b;
        end else if (idx_c == 4'd4) begin
          vlo_nxt = b;
        end else if (idx_c == 4'd5) begin
          flg_nxt = b;
        end else begin
          size_nxt = size_new;
          if (idx_c == 4'd9) begin
            idx_nxt = idx_c;
            if (frame_fits(cons_c, size_new)) begin
              phase_nxt = PH_FHDR;
              idx_nxt   = 4'd0;
              id_nxt    = '0;
              len_nxt   = '0;
            end else begin
              phase_nxt = PH_DONE;
            end
            res_valid         = 1'b1;
            res.event_res     = EV_TAG_HDR;
            res.major_version = vhi_r;
            res.minor_version = vlo_r;
            res.tag_flags     = flg_r;
            res.tag_size      = size_new;
          end
        end
      end

      PH_BAD: begin
        if (idx_c >= 4'd2) begin
          phase_nxt     = PH_DONE;
          res_valid     = 1'b1;
          res.event_res = EV_NOT_ID3;
        end else begin
          idx_nxt = idx_c + 4'd1;
        end
      end

      PH_FHDR: begin
        priority if (idx_c < 4'd4) begin
          id_nxt  = id_new;
          idx_nxt = idx_c + 4'd1;
          // all-zero frame ID is padding: end of tag
          if (idx_c == 4'd3 && id_new == 32'd0) begin
            phase_nxt = PH_DONE;
            idx_nxt   = idx_c;
          end
        end else if (idx_c < 4'd8) begin
          len_nxt = ss_or(len_r, b, idx_c[1:0]);
          idx_nxt = idx_c + 4'd1;
        end else if (idx_c == 4'd8) begin
          idx_nxt = idx_c + 4'd1;
        end else begin
          // last header byte: frame must fit inside the tag
          if (total > {3'b0, size_c}) begin
            phase_nxt = PH_DONE;
          end else begin
            cons_nxt = cons_new;
            kind_nxt = kind_hit;
            left_nxt = len_r;
            if (len_r == 29'd0) begin
              if (frame_fits(cons_new, size_c)) begin
                phase_nxt = PH_FHDR;
                idx_nxt   = 4'd0;
                id_nxt    = '0;
                len_nxt   = '0;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt = known ? PH_ENC : PH_SKIP;
            end
            if (known) begin
              res_valid         = 1'b1;
              res.event_res     = EV_FRAME_START;
              res.frame_kind    = kind_hit;
              res.last_of_frame = (len_r <= 29'd1);
            end
          end
        end
      end

      PH_SKIP, PH_ENC, PH_TEXT: begin
        left_nxt = left_dec;
        if (left_dec == 29'd0) begin
          if (frame_fits(cons_c, size_c)) begin
            phase_nxt = PH_FHDR;
            idx_nxt   = 4'd0;
            id_nxt    = '0;
            len_nxt   = '0;
          end else begin
            phase_nxt = PH_DONE;
          end
        end else if (ph_c == PH_ENC) begin
          // encoding byte dropped
          phase_nxt = PH_TEXT;
        end
        if (ph_c == PH_TEXT) begin
          res_valid         = 1'b1;
          res.event_res     = EV_TEXT_BYTE;
          res.frame_kind    = kind_r;
          res.text_byte     = b;
          res.last_of_frame = (left_dec == 29'd0);
        end
      end

      PH_IDLE, PH_DONE: begin
        // bytes ignored until the next start
      end

      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // state registers, updated on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      size_r  <= '0;
      cons_r  <= '0;
      id_r    <= '0;
      len_r   <= '0;
      left_r  <= '0;
      kind_r  <= '0;
      vhi_r   <= '0;
      vlo_r   <= '0;
      flg_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      size_r  <= size_nxt;
      cons_r  <= cons_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      kind_r  <= kind_nxt;
      vhi_r   <= vhi_nxt;
      vlo_r   <= vlo_nxt;
      flg_r   <= flg_nxt;
    end
  end

endmodule : id3p_core
`default_nettype wire

// File: rtl/id3p_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module id3p_out_reg
  import id3p_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,       // parser processes an item this cycle
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         free,       // slot empty or being drained
  id3p_out_if.source   out_if
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res_valid;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_r <= res;
    end
  end

  assign out_if.valid         = valid_r;
  assign out_if.event_res     = res_r.event_res;
  assign out_if.frame_kind    = res_r.frame_kind;
  assign out_if.text_byte     = res_r.text_byte;
  assign out_if.last_of_frame = res_r.last_of_frame;
  assign out_if.major_version = res_r.major_version;
  assign out_if.minor_version = res_r.minor_version;
  assign out_if.tag_flags     = res_r.tag_flags;
  assign out_if.tag_size      = res_r.tag_size;

endmodule : id3p_out_reg
`default_nettype wire
